FILE: src/css_pkg.sv
package css_pkg;

	// action codes carried by a command word
	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_DONE  = 2'd1,
		ACT_FAIL  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	// stage codes
	localparam logic [3:0] STAGE_IDLE     = 4'd0;
	localparam logic [3:0] STAGE_FIRST    = 4'd1;
	localparam logic [3:0] STAGE_LAST     = 4'd8;
	localparam logic [3:0] STAGE_COMPLETE = 4'd9;
	localparam logic [3:0] STAGE_FAILED   = 4'd10;

	localparam int unsigned PCT_FULL  = 100;
	localparam int unsigned NUM_WORK  = 8;

	typedef struct packed {
		logic [3:0] stage;
		logic [8:0] mask;
		logic [3:0] fail_stage;
		logic [7:0] fail_reason;
		logic       active;
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] procedure;
		logic [7:0] reason;
	} cmd_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] expected_proc;
		logic       workflow_done;
		logic [3:0] current_stage;
		logic [8:0] done_mask;
		logic [3:0] failed_at;
		logic [7:0] failure_code;
		logic [6:0] progress_percent;
		logic       running;
	} status_t;

	function automatic logic is_working(logic [3:0] s);
		return (s >= STAGE_FIRST) && (s <= STAGE_LAST);
	endfunction

	// (s-1)*100/8 for a working stage
	function automatic logic [6:0] pct_of(logic [3:0] s);
		logic [9:0] prod;
		prod = 10'(s - STAGE_FIRST) * 10'(PCT_FULL);
		return 7'(prod / 10'(NUM_WORK));
	endfunction

endpackage

FILE: src/css_cmd_if.sv
interface css_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [3:0] procedure;
	logic [7:0] reason;

	modport source (output valid, output action, output procedure, output reason,
		input ready);
	modport sink (input valid, input action, input procedure, input reason,
		output ready);
endinterface

FILE: src/css_status_if.sv
interface css_status_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [3:0] expected_proc;
	logic       workflow_done;
	logic [3:0] current_stage;
	logic [8:0] done_mask;
	logic [3:0] failed_at;
	logic [7:0] failure_code;
	logic [6:0] progress_percent;
	logic       running;

	modport source (output valid, output accepted, output expected_proc,
		output workflow_done, output current_stage, output done_mask,
		output failed_at, output failure_code, output progress_percent,
		output running, input ready);
	modport sink (input valid, input accepted, input expected_proc,
		input workflow_done, input current_stage, input done_mask,
		input failed_at, input failure_code, input progress_percent,
		input running, output ready);
endinterface

FILE: src/css_step.sv
module css_step (
	input  css_pkg::state_t  cur,
	input  css_pkg::cmd_t    cmd,
	output css_pkg::state_t  nxt,
	output css_pkg::status_t res
);

	logic [3:0] expect_proc;
	logic       acc;
	logic       done;

	assign expect_proc = css_pkg::is_working(cur.stage) ? cur.stage : css_pkg::STAGE_IDLE;

	always_comb begin
		nxt  = cur;
		acc  = 1'b0;
		done = 1'b0;
		case (css_pkg::action_t'(cmd.action))
			css_pkg::ACT_START: begin
				if (!cur.active) begin
					nxt        = '0;
					nxt.active = 1'b1;
					nxt.stage  = css_pkg::STAGE_FIRST;
					acc        = 1'b1;
				end
			end
			css_pkg::ACT_DONE: begin
				if (cur.active && (expect_proc != css_pkg::STAGE_IDLE)
						&& (cmd.procedure == expect_proc)) begin
					nxt.mask = cur.mask | (9'd1 << cur.stage);
					if (cur.stage == css_pkg::STAGE_LAST) begin
						nxt.stage  = css_pkg::STAGE_COMPLETE;
						nxt.active = 1'b0;
						done       = 1'b1;
					end else begin
						nxt.stage = cur.stage + 4'd1;
					end
					acc = 1'b1;
				end
			end
			css_pkg::ACT_FAIL: begin
				if (cur.active) begin
					nxt.fail_stage  = cur.stage;
					nxt.fail_reason = cmd.reason;
					nxt.stage       = css_pkg::STAGE_FAILED;
					nxt.active      = 1'b0;
					acc             = 1'b1;
				end
			end
			default: begin
				acc = 1'b1;
			end
		endcase
	end

	always_comb begin
		res.accepted       = acc;
		res.workflow_done  = done;
		res.current_stage  = nxt.stage;
		res.done_mask      = nxt.mask;
		res.failed_at      = nxt.fail_stage;
		res.failure_code   = nxt.fail_reason;
		res.running        = nxt.active;
		res.expected_proc  = (nxt.active && css_pkg::is_working(nxt.stage)) ?
			nxt.stage : css_pkg::STAGE_IDLE;
		if (nxt.stage == css_pkg::STAGE_COMPLETE) begin
			res.progress_percent = 7'(css_pkg::PCT_FULL);
		end else if (nxt.stage == css_pkg::STAGE_FAILED) begin
			res.progress_percent = css_pkg::is_working(nxt.fail_stage) ?
				css_pkg::pct_of(nxt.fail_stage) : 7'd0;
		end else if (css_pkg::is_working(nxt.stage)) begin
			res.progress_percent = css_pkg::pct_of(nxt.stage);
		end else begin
			res.progress_percent = 7'd0;
		end
	end

endmodule

FILE: src/commissioning_stage_sequencer.sv
// commissioning stage sequencer: one status word per command word
// a command word passes through the command register, then the status register,
// before its status word is valid
// throughput: one command word per cycle while status words are taken (status.ready)
// reset: arst_n clears the run state to idle and empties both registers
module commissioning_stage_sequencer (
	input logic           clk,
	input logic           arst_n,
	css_cmd_if.sink       cmd,
	css_status_if.source  status
);

	// input register stage
	logic             vld_s1;
	css_pkg::cmd_t    cmd_s1;
	// result register stage
	logic             vld_s2;
	css_pkg::status_t res_s2;
	// run state
	css_pkg::state_t  st_q;

	css_pkg::state_t  st_nxt;
	css_pkg::status_t res_nxt;

	logic load_s2;
	logic adv_s1;

	// the result register frees up when its word is taken or it is empty
	assign load_s2   = !vld_s2 || status.ready;
	assign adv_s1    = vld_s1 && load_s2;
	assign cmd.ready = !vld_s1 || load_s2;

	css_step u_step (
		.cur (st_q),
		.cmd (cmd_s1),
		.nxt (st_nxt),
		.res (res_nxt)
	);

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.action    <= cmd.action;
			cmd_s1.procedure <= cmd.procedure;
			cmd_s1.reason    <= cmd.reason;
		end
	end

	// run state moves only when the command moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign status.valid            = vld_s2;
	assign status.accepted         = res_s2.accepted;
	assign status.expected_proc    = res_s2.expected_proc;
	assign status.workflow_done    = res_s2.workflow_done;
	assign status.current_stage    = res_s2.current_stage;
	assign status.done_mask        = res_s2.done_mask;
	assign status.failed_at        = res_s2.failed_at;
	assign status.failure_code     = res_s2.failure_code;
	assign status.progress_percent = res_s2.progress_percent;
	assign status.running          = res_s2.running;

	// active run always sits in a working stage
	a_active_stage: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active == css_pkg::is_working(st_q.stage))
		else $error("run flag and stage disagree");

	// a finished run reports every working stage done
	a_done_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && status.workflow_done) |->
		(status.accepted && (status.done_mask == 9'h1FE)
		&& (status.current_stage == css_pkg::STAGE_COMPLETE) && !status.running))
		else $error("completion word with incomplete mask");

	// a running word expects the procedure of its stage
	a_running_proc: assert property (@(posedge clk) disable iff (!arst_n)
		(status.valid && status.running) |->
		(status.expected_proc == status.current_stage))
		else $error("expected procedure does not follow stage");

	// state changes only when a command moves through
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(st_q))
		else $error("run state moved without a command");

endmodule
